/* rtl/gbn_pkg.sv */
package gbn_pkg;

  localparam int unsigned WINDOW_DEF = 8;
  localparam int unsigned BUFFER_DEPTH_DEF = 64;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] PERIOD_RESET = 16'd5000;

  localparam logic [1:0] MODE_MSG = 2'd0;
  localparam logic [1:0] MODE_ACK = 2'd1;
  localparam logic [1:0] MODE_TMO = 2'd2;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  localparam logic [1:0] TMR_NONE = 2'd0;
  localparam logic [1:0] TMR_START = 2'd1;
  localparam logic [1:0] TMR_STOP = 2'd2;
  localparam logic [1:0] TMR_RESTART = 2'd3;

  typedef struct packed {
    logic [1:0]  mode;
    logic [63:0] payload_low;
    logic [63:0] payload_mid;
    logic [31:0] payload_high;
    logic [30:0] ack_seq;
    logic [31:0] ack_flag;
    logic [31:0] checksum_in;
  } in_item_t;

  typedef struct packed {
    logic        send_valid;
    logic [30:0] seq_out;
    logic [63:0] data_low_out;
    logic [63:0] data_mid_out;
    logic [31:0] data_high_out;
    logic [15:0] crc_out;
    logic [1:0]  timer_action;
    logic [15:0] timer_load;
    logic        dropped;
    logic        last;
  } out_item_t;

  // one byte of the packet image a cycle into the serial CRC
  typedef struct packed {
    logic       start;
    logic       en;
    logic [7:0] data;
  } crc_ctl_t;

endpackage

/* rtl/gbn_ram.sv */
module gbn_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/gbn_crc.sv */
module gbn_crc (
  input  logic              clk,
  input  gbn_pkg::crc_ctl_t ctl,
  output logic [15:0]       crc
);

  logic [15:0] crc_next;

  // byte-wide step, eight narrow shift-xor stages
  always_comb begin
    logic [15:0] c;
    c = (ctl.start ? 16'h0000 : crc) ^ {ctl.data, 8'h00};
    for (int j = 0; j < 8; j++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ gbn_pkg::CRC_POLY) : {c[14:0], 1'b0};
    end
    crc_next = c;
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      crc <= crc_next;
    end else if (ctl.start) begin
      crc <= '0;
    end
  end

endmodule

/* rtl/go_back_n_sender_top.sv */
// Mode 0 and 1: byte-serial CRC over the 32-byte packet image, then a decide state gives
// the result; a refused message (buffer full) goes straight to decide, skipping the CRC.
// Mode 2: each resent packet goes through store read, read wait and output; store read
// holds while a result waits unaccepted. Nothing outstanding: status from store read.
// A depth that is not a power of two adds a slot reduction of the base before the first
// read. One item at a time. Reset (rst, sync): base, next sequence 0, period 5000.
module go_back_n_sender_top #(
  parameter int unsigned WINDOW = gbn_pkg::WINDOW_DEF,
  parameter int unsigned BUFFER_DEPTH = gbn_pkg::BUFFER_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  gbn_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output gbn_pkg::out_item_t out_data
);

  localparam int unsigned AW = $clog2(BUFFER_DEPTH);
  localparam bit POW2 = (BUFFER_DEPTH == (1 << AW));
  localparam logic [AW:0] DEPTH_W = (AW+1)'(BUFFER_DEPTH);
  localparam logic [AW-1:0] LAST_SLOT = AW'(BUFFER_DEPTH - 1);

  typedef enum logic [2:0] {
    IDLE, CRC, DECIDE, SLOT, RD, RDWAIT, EMIT
  } state_t;

  state_t state;
  logic [15:0] timer_period;
  logic [30:0] window_base, next_sequence;
  gbn_pkg::in_item_t item;
  logic [255:0] shreg;
  logic [4:0] bcnt;
  logic [5:0] rcnt, rn;
  logic [30:0] rseq;
  gbn_pkg::crc_ctl_t cctl;
  logic [15:0] crc;
  logic [AW-1:0] waddr, raddr;
  logic [AW-1:0] wslot, rslot;
  logic [AW:0] slot_t;
  logic we;
  logic [175:0] wdata, rdata;
  logic [30:0] outstanding, ack_dist;
  logic full, keep, ack_ok, emit_last;
  logic [1:0] dec_act;

  assign outstanding = next_sequence - window_base;
  assign ack_dist = item.ack_seq - window_base;
  assign in_ready = (state == IDLE) && !out_valid;
  assign cctl.start = (state == IDLE);
  assign cctl.en = (state == CRC);
  assign cctl.data = shreg[7:0];

  gbn_crc u_crc (.clk(clk), .ctl(cctl), .crc(crc));

  assign full = (outstanding >= 31'(BUFFER_DEPTH));
  assign keep = (item.mode == gbn_pkg::MODE_MSG) && !full;
  assign ack_ok = (item.mode == gbn_pkg::MODE_ACK) && (item.checksum_in == {16'h0, crc}) &&
                  (item.ack_flag == 32'd1) && (ack_dist < outstanding);
  assign dec_act = keep ? ((outstanding == '0) ? gbn_pkg::TMR_START : gbn_pkg::TMR_NONE) :
                   ack_ok ? (((item.ack_seq + 31'd1) == next_sequence) ? gbn_pkg::TMR_STOP
                                                                       : gbn_pkg::TMR_RESTART) :
                   gbn_pkg::TMR_NONE;
  assign emit_last = (rcnt + 6'd1 == rn);
  assign slot_t = {rslot, shreg[30]};

  // wslot tracks next_sequence mod depth, rslot the sequence being resent
  assign waddr = wslot;
  assign raddr = rslot;

  assign we = (state == DECIDE) && keep;
  assign wdata = {item.payload_low, item.payload_mid, item.payload_high, crc};

  gbn_ram #(.WIDTH(176), .DEPTH(BUFFER_DEPTH)) u_store (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  function automatic gbn_pkg::out_item_t make_result(logic send, logic [30:0] seq,
                                                     logic [175:0] pkt, logic [1:0] act,
                                                     logic drop, logic fin);
    gbn_pkg::out_item_t r;
    r.send_valid = send;
    r.seq_out = seq;
    {r.data_low_out, r.data_mid_out, r.data_high_out, r.crc_out} = pkt;
    r.timer_action = act;
    r.timer_load = timer_period;
    r.dropped = drop;
    r.last = fin;
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      timer_period <= gbn_pkg::PERIOD_RESET;
      window_base <= '0;
      next_sequence <= '0;
      wslot <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        timer_period <= cfg_wdata;
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (in_valid && in_ready) begin
            item <= in_data;
            bcnt <= '0;
            unique case (in_data.mode)
              gbn_pkg::MODE_MSG: begin
                shreg <= {in_data.payload_high, in_data.payload_mid, in_data.payload_low,
                          32'h0, 32'h0, 1'b0, next_sequence};
                state <= full ? DECIDE : CRC;
              end
              gbn_pkg::MODE_ACK: begin
                shreg <= {in_data.payload_high, in_data.payload_mid, in_data.payload_low,
                          32'h0, in_data.ack_flag, 1'b0, in_data.ack_seq};
                state <= CRC;
              end
              gbn_pkg::MODE_TMO: begin
                rseq <= window_base;
                rcnt <= '0;
                rn <= (outstanding < 31'(WINDOW)) ? outstanding[5:0] : 6'(WINDOW);
                shreg <= {225'h0, window_base};
                rslot <= POW2 ? window_base[AW-1:0] : '0;
                state <= POW2 ? RD : SLOT;
              end
              default: state <= IDLE;
            endcase
          end
        end
        CRC: begin
          shreg <= {8'h00, shreg[255:8]};
          bcnt <= bcnt + 5'd1;
          if (bcnt == 5'd31) begin
            state <= DECIDE;
          end
        end
        DECIDE: begin
          out_valid <= 1'b1;
          out_data <= make_result(keep && (outstanding < 31'(WINDOW)),
                                  keep ? next_sequence : '0, keep ? wdata : '0, dec_act,
                                  full && (item.mode == gbn_pkg::MODE_MSG), 1'b1);
          state <= IDLE;
          if (keep) begin
            next_sequence <= next_sequence + 31'd1;
            wslot <= ((next_sequence == '1) || (wslot == LAST_SLOT)) ? '0 : wslot + AW'(1);
          end
          if (ack_ok) begin
            window_base <= item.ack_seq + 31'd1;
          end
        end
        SLOT: begin
          // base mod depth, one sequence bit a cycle, MSB first
          shreg <= {shreg[254:0], 1'b0};
          rslot <= (slot_t >= DEPTH_W) ? AW'(slot_t - DEPTH_W) : slot_t[AW-1:0];
          bcnt <= bcnt + 5'd1;
          if (bcnt == 5'd30) begin
            state <= RD;
          end
        end
        RD: begin
          if (!out_valid) begin
            if (rn == '0) begin
              out_valid <= 1'b1;
              out_data <= make_result(1'b0, '0, '0, gbn_pkg::TMR_NONE, 1'b0, 1'b1);
              state <= IDLE;
            end else begin
              state <= RDWAIT;
            end
          end
        end
        RDWAIT: state <= EMIT;
        EMIT: begin
          out_valid <= 1'b1;
          out_data <= make_result(1'b1, rseq, rdata,
                                  emit_last ? gbn_pkg::TMR_START : gbn_pkg::TMR_NONE,
                                  1'b0, emit_last);
          rseq <= rseq + 31'd1;
          rslot <= ((rseq == '1) || (rslot == LAST_SLOT)) ? '0 : rslot + AW'(1);
          rcnt <= rcnt + 6'd1;
          state <= emit_last ? IDLE : RD;
        end
        default: state <= IDLE;
      endcase
    end
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != IDLE) |-> !in_ready) else $error("accept while busy");
  a_window: assert property (@(posedge clk) disable iff (rst)
    outstanding <= 31'(BUFFER_DEPTH)) else $error("buffer overrun");
  a_crc_len: assert property (@(posedge clk) disable iff (rst)
    (state == DECIDE && item.mode != gbn_pkg::MODE_MSG) |-> $past(state) == CRC)
    else $error("ack decided without crc");

endmodule

/* dv/go_back_n_sender_top_tb.sv */
`timescale 1ns / 100ps

module go_back_n_sender_top_tb;

  localparam int unsigned WIN = gbn_pkg::WINDOW_DEF;
  localparam int unsigned DEPTH = gbn_pkg::BUFFER_DEPTH_DEF;
  localparam int unsigned SLOT_W = $clog2(DEPTH);
  localparam int unsigned CYCLE_LIMIT = 1000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  gbn_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  gbn_pkg::out_item_t out_data;

  always #6 clk = ~clk;

  go_back_n_sender_top DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // sender state mirror
  logic [15:0] period_q;
  logic [30:0] base_q, next_q;
  logic [63:0] lo_q [DEPTH];
  logic [63:0] mid_q [DEPTH];
  logic [31:0] hi_q [DEPTH];
  logic [15:0] crc_q [DEPTH];

  gbn_pkg::out_item_t pending_q [$];
  int errors = 0;
  int n_items = 0, n_results = 0, n_sends = 0, n_drops = 0, n_acks_taken = 0;
  int cycles = 0;
  logic stall_mode = 1'b0;

  function automatic logic [15:0] crc_bytes(logic [15:0] c, logic [63:0] w, int nb);
    for (int i = 0; i < nb; i++) begin
      c = c ^ {w[8*i +: 8], 8'h00};
      for (int j = 0; j < 8; j++) begin
        if (c[15]) c = (c << 1) ^ gbn_pkg::CRC_POLY;
        else c = c << 1;
      end
    end
    return c;
  endfunction

  function automatic logic [15:0] image_crc(logic [30:0] seq, logic [31:0] ackw,
                                            logic [63:0] lo, logic [63:0] mid,
                                            logic [31:0] hi);
    logic [15:0] c;
    c = crc_bytes(16'h0, {33'h0, seq}, 4);
    c = crc_bytes(c, {32'h0, ackw}, 4);
    c = crc_bytes(c, 64'h0, 4);
    c = crc_bytes(c, lo, 8);
    c = crc_bytes(c, mid, 8);
    c = crc_bytes(c, {32'h0, hi}, 4);
    return c;
  endfunction

  function automatic gbn_pkg::out_item_t status_item(logic [1:0] act);
    gbn_pkg::out_item_t r;
    r = '0;
    r.timer_action = act;
    r.timer_load = period_q;
    r.last = 1'b1;
    return r;
  endfunction

  // advance sender mirror by one event and queue what it should emit
  task automatic predict_event(gbn_pkg::in_item_t it);
    gbn_pkg::out_item_t r;
    logic [30:0] outstanding, ack_dist, seq;
    logic [SLOT_W-1:0] slot;
    logic [15:0] c;
    int n;
    outstanding = next_q - base_q;
    case (it.mode)
      gbn_pkg::MODE_MSG: begin
        if (outstanding >= 31'(DEPTH)) begin
          r = status_item(gbn_pkg::TMR_NONE);
          r.timer_load = period_q;
          r.dropped = 1'b1;
          pending_q.push_back(r);
        end else begin
          seq = next_q;
          slot = SLOT_W'(seq % DEPTH);
          c = image_crc(seq, 32'h0, it.payload_low, it.payload_mid, it.payload_high);
          lo_q[slot] = it.payload_low;
          mid_q[slot] = it.payload_mid;
          hi_q[slot] = it.payload_high;
          crc_q[slot] = c;
          r = status_item(gbn_pkg::TMR_NONE);
          r.send_valid = (outstanding < 31'(WIN));
          if (outstanding == 0) r.timer_action = gbn_pkg::TMR_START;
          r.seq_out = seq;
          r.data_low_out = it.payload_low;
          r.data_mid_out = it.payload_mid;
          r.data_high_out = it.payload_high;
          r.crc_out = c;
          next_q = next_q + 31'd1;
          pending_q.push_back(r);
        end
      end
      gbn_pkg::MODE_ACK: begin
        c = image_crc(it.ack_seq, it.ack_flag, it.payload_low, it.payload_mid,
                      it.payload_high);
        ack_dist = it.ack_seq - base_q;
        r = status_item(gbn_pkg::TMR_NONE);
        if (it.checksum_in == {16'h0, c} && it.ack_flag == 32'd1 && ack_dist < outstanding) begin
          base_q = it.ack_seq + 31'd1;
          r.timer_action = (base_q == next_q) ? gbn_pkg::TMR_STOP : gbn_pkg::TMR_RESTART;
          n_acks_taken++;
        end
        pending_q.push_back(r);
      end
      gbn_pkg::MODE_TMO: begin
        n = (outstanding < 31'(WIN)) ? int'(outstanding) : int'(WIN);
        if (n == 0) pending_q.push_back(status_item(gbn_pkg::TMR_NONE));
        for (int i = 0; i < n; i++) begin
          seq = base_q + 31'(i);
          slot = SLOT_W'(seq % DEPTH);
          r = status_item(gbn_pkg::TMR_NONE);
          r.send_valid = 1'b1;
          r.seq_out = seq;
          r.data_low_out = lo_q[slot];
          r.data_mid_out = mid_q[slot];
          r.data_high_out = hi_q[slot];
          r.crc_out = crc_q[slot];
          r.last = (i == n - 1);
          r.timer_action = r.last ? gbn_pkg::TMR_START : gbn_pkg::TMR_NONE;
          pending_q.push_back(r);
        end
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // result check
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && out_valid && out_ready) begin
      if (pending_q.size() == 0) begin
        report_mismatch("unexpected result", 64'(out_data.seq_out), 64'h0);
      end else begin
        gbn_pkg::out_item_t w;
        w = pending_q.pop_front();
        n_results++;
        if (out_data.send_valid) n_sends++;
        if (out_data.dropped) n_drops++;
        if (out_data.send_valid !== w.send_valid)
          report_mismatch("send_valid", 64'(out_data.send_valid), 64'(w.send_valid));
        if (out_data.seq_out !== w.seq_out)
          report_mismatch("seq_out", 64'(out_data.seq_out), 64'(w.seq_out));
        if (out_data.data_low_out !== w.data_low_out)
          report_mismatch("data_low_out", out_data.data_low_out, w.data_low_out);
        if (out_data.data_mid_out !== w.data_mid_out)
          report_mismatch("data_mid_out", out_data.data_mid_out, w.data_mid_out);
        if (out_data.data_high_out !== w.data_high_out)
          report_mismatch("data_high_out", 64'(out_data.data_high_out), 64'(w.data_high_out));
        if (out_data.crc_out !== w.crc_out)
          report_mismatch("crc_out", 64'(out_data.crc_out), 64'(w.crc_out));
        if (out_data.timer_action !== w.timer_action)
          report_mismatch("timer_action", 64'(out_data.timer_action), 64'(w.timer_action));
        if (out_data.timer_load !== w.timer_load)
          report_mismatch("timer_load", 64'(out_data.timer_load), 64'(w.timer_load));
        if (out_data.dropped !== w.dropped)
          report_mismatch("dropped", 64'(out_data.dropped), 64'(w.dropped));
        if (out_data.last !== w.last)
          report_mismatch("last", 64'(out_data.last), 64'(w.last));
      end
    end
  end

  // receiver stall pattern
  int stall_left = 0;
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (stall_mode && $urandom_range(0, 3) == 0) begin
      stall_left <= gap_len();
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout: %0d results still pending", pending_q.size());
      $display("go_back_n_sender_top_tb: errors");
      $finish;
    end
  end

  // valid stays up across back-to-back transfers, drops only for a gap
  task automatic send_item(gbn_pkg::in_item_t it);
    int g;
    g = stall_mode ? gap_len() : 0;
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_data <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_event(it);
    n_items++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    // a mode 3 item can still be in flight
    repeat (50) @(posedge clk);
  endtask

  task automatic write_period(logic [15:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    period_q = v;
  endtask

  function automatic gbn_pkg::in_item_t msg_item(logic [63:0] lo, logic [63:0] mid,
                                                 logic [31:0] hi);
    gbn_pkg::in_item_t it;
    it = '0;
    it.mode = gbn_pkg::MODE_MSG;
    it.payload_low = lo;
    it.payload_mid = mid;
    it.payload_high = hi;
    return it;
  endfunction

  // well-formed ACK, optionally corrupted
  function automatic gbn_pkg::in_item_t ack_item(logic [30:0] seq, int flaw);
    gbn_pkg::in_item_t it;
    it = '0;
    it.mode = gbn_pkg::MODE_ACK;
    it.payload_low = {$urandom, $urandom};
    it.payload_mid = {$urandom, $urandom};
    it.payload_high = $urandom;
    it.ack_seq = seq;
    it.ack_flag = 32'd1;
    if (flaw == 2) it.ack_flag = ($urandom_range(0, 1) != 0) ? $urandom : 32'd0;
    it.checksum_in = {16'h0, image_crc(it.ack_seq, it.ack_flag, it.payload_low,
                                       it.payload_mid, it.payload_high)};
    if (flaw == 1) it.checksum_in = it.checksum_in ^ (32'd1 << $urandom_range(0, 31));
    return it;
  endfunction

  function automatic gbn_pkg::in_item_t tmo_item();
    gbn_pkg::in_item_t it;
    it.mode = gbn_pkg::MODE_TMO;
    it.payload_low = {$urandom, $urandom};
    it.payload_mid = {$urandom, $urandom};
    it.payload_high = $urandom;
    it.ack_seq = 31'($urandom);
    it.ack_flag = $urandom;
    it.checksum_in = $urandom;
    return it;
  endfunction

  typedef struct {
    gbn_pkg::in_item_t  it;
    logic               typed;
    gbn_pkg::out_item_t want;
  } row_t;

  row_t rows [$];

  task automatic add_row(gbn_pkg::in_item_t it, logic typed, gbn_pkg::out_item_t want);
    row_t r;
    r.it = it;
    r.typed = typed;
    r.want = want;
    rows.push_back(r);
  endtask

  initial begin
    gbn_pkg::in_item_t it;
    gbn_pkg::out_item_t w;
    int k;
    int p;
    period_q = gbn_pkg::PERIOD_RESET;
    base_q = '0;
    next_q = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    w = '0; w.timer_load = gbn_pkg::PERIOD_RESET; w.last = 1'b1;
    add_row(tmo_item(), 1'b1, w);                      // timeout, nothing outstanding
    add_row(ack_item(31'd0, 0), 1'b1, w);              // ACK with nothing outstanding
    add_row(msg_item('0, '0, '0), 1'b0, '0);
    add_row(msg_item('1, '1, '1), 1'b0, '0);
    add_row(msg_item(64'h0123456789abcdef, 64'hfedcba9876543210, 32'h5a5aa5a5), 1'b0, '0);
    add_row(ack_item(31'd1, 1), 1'b0, '0);             // corrupt CRC
    add_row(ack_item(31'd1, 2), 1'b0, '0);             // not an ACK
    add_row(ack_item(31'd5, 0), 1'b0, '0);             // future ACK
    add_row(ack_item(31'h7fffffff, 0), 1'b0, '0);      // stale ACK
    add_row(tmo_item(), 1'b0, '0);
    add_row(ack_item(31'd0, 0), 1'b0, '0);             // slide, restart
    for (int i = 0; i < 8; i++) add_row(msg_item({$urandom, $urandom}, '1, $urandom), 1'b0, '0);
    add_row(tmo_item(), 1'b0, '0);                     // window-limited resend
    add_row(ack_item(31'd10, 0), 1'b0, '0);            // last ACK, stop
    it = tmo_item(); it.mode = gbn_pkg::MODE_UNUSED;
    add_row(it, 1'b0, '0);                             // unused mode, no result
    add_row(tmo_item(), 1'b0, '0);

    foreach (rows[i]) begin
      send_item(rows[i].it);
      if (rows[i].typed) pending_q[pending_q.size() - 1] = rows[i].want;
    end
    drain();

    // random phases across period settings
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: write_period(16'd1);
        1: write_period(16'hffff);
        2: write_period(16'($urandom_range(2, 65534)));
        3: write_period(16'($urandom_range(1, 65535)));
        default: write_period(gbn_pkg::PERIOD_RESET);
      endcase
      stall_mode = (ph != 2);
      for (k = 0; k < 86; k++) begin
        p = $urandom_range(0, 99);
        if (ph == 3 && p < 70) begin
          // push toward buffer full
          it = msg_item({$urandom, $urandom}, {$urandom, $urandom}, $urandom);
        end else if (p < 45) begin
          it = msg_item({$urandom, $urandom}, {$urandom, $urandom}, $urandom);
        end else if (p < 75) begin
          logic [30:0] outs;
          outs = next_q - base_q;
          if (outs != 0)
            it = ack_item(base_q + 31'($urandom_range(0, int'(outs) - 1)), 0);
          else
            it = ack_item(31'($urandom), 0);
        end else if (p < 85) begin
          it = tmo_item();
        end else if (p < 92) begin
          it = ack_item(31'($urandom), $urandom_range(0, 2));
        end else begin
          it = ack_item(next_q - 31'($urandom_range(0, 3)), $urandom_range(1, 2));
        end
        send_item(it);
      end
      drain();
    end

    $display("%0d items, %0d results (%0d packets sent, %0d drops, %0d ACKs taken)",
             n_items, n_results, n_sends, n_drops, n_acks_taken);
    $display("periods 1, 65535, random and reset value; final base %0d next %0d",
             base_q, next_q);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("go_back_n_sender_top_tb: clean");
    end else begin
      $display("go_back_n_sender_top_tb: errors");
    end
    $finish;
  end

endmodule
